@@ rtl/md4_pkg.sv @@
// shared types, constants and control store for the md4 digest unit
package md4_pkg;

   localparam int UC_AW = 6;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hefcdab89;
   localparam logic [31:0] IV2 = 32'h98badcfe;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] K2  = 32'h5a827999;
   localparam logic [31:0] K3  = 32'h6ed9eba1;

   // message word used by each of the 48 round steps, step 0 in the low nibble
   localparam logic [47:0][3:0] WORD_ORDER =
      192'hf7b3d591e6a2c480_fb73ea62d951c840_fedcba9876543210;

   // control store addresses
   localparam logic [UC_AW-1:0] ADDR_WAIT   = 6'd0;
   localparam logic [UC_AW-1:0] ADDR_LOAD   = 6'd1;
   localparam logic [UC_AW-1:0] ADDR_R0     = 6'd2;
   localparam logic [UC_AW-1:0] ADDR_R_LAST = 6'd49;
   localparam logic [UC_AW-1:0] ADDR_ADD    = 6'd50;
   localparam logic [UC_AW-1:0] ADDR_PAD    = 6'd51;
   localparam logic [UC_AW-1:0] ADDR_LEN    = 6'd52;
   localparam logic [UC_AW-1:0] ADDR_EMIT   = 6'd53;

   typedef enum logic [2:0] {
      UC_WAIT,
      UC_LOAD,
      UC_ROUND,
      UC_ADD,
      UC_PAD,
      UC_LEN,
      UC_EMIT
   } md4_op_type;

   // where the sequencer goes once a compression has been folded in
   typedef enum logic [1:0] {
      RET_IDLE,
      RET_PAD,
      RET_LEN,
      RET_EMIT
   } md4_ret_type;

   typedef struct packed {
      md4_op_type  op;
      logic [1:0]  rnd;
      logic [3:0]  widx;
      logic [4:0]  rot;
   } md4_uc_type;

   typedef struct packed {
      logic blk_full;   // next byte completes a 64-byte block
      logic pos_hi;     // fewer than 8 bytes free for the length
      logic emit_last;  // fourth digest word goes out this cycle
   } md4_stat_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } md4_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } md4_rsp_type;

   function automatic logic [4:0] md4_rot(input logic [1:0] rnd, input logic [1:0] slot);
      logic [4:0] r;
      r = 5'd3;
      unique case ({rnd, slot})
         4'b00_00, 4'b01_00, 4'b10_00: r = 5'd3;
         4'b00_01: r = 5'd7;
         4'b00_10: r = 5'd11;
         4'b00_11: r = 5'd19;
         4'b01_01: r = 5'd5;
         4'b01_10: r = 5'd9;
         4'b01_11: r = 5'd13;
         4'b10_01: r = 5'd9;
         4'b10_10: r = 5'd11;
         4'b10_11: r = 5'd15;
         default:  r = 5'd3;
      endcase
      return r;
   endfunction

   // read-only control store
   function automatic md4_uc_type md4_ucode(input logic [UC_AW-1:0] addr);
      md4_uc_type uc;
      logic [5:0] n;
      n       = addr - ADDR_R0;
      uc.op   = UC_WAIT;
      uc.rnd  = 2'd0;
      uc.widx = 4'd0;
      uc.rot  = 5'd0;
      priority if (addr == ADDR_LOAD) begin
         uc.op = UC_LOAD;
      end else if (addr >= ADDR_R0 && addr <= ADDR_R_LAST) begin
         uc.op   = UC_ROUND;
         uc.rnd  = n[5:4];
         uc.widx = WORD_ORDER[n];
         uc.rot  = md4_rot(n[5:4], n[1:0]);
      end else if (addr == ADDR_ADD) begin
         uc.op = UC_ADD;
      end else if (addr == ADDR_PAD) begin
         uc.op = UC_PAD;
      end else if (addr == ADDR_LEN) begin
         uc.op = UC_LEN;
      end else if (addr == ADDR_EMIT) begin
         uc.op = UC_EMIT;
      end else begin
         uc.op = UC_WAIT;
      end
      return uc;
   endfunction

endpackage

@@ rtl/md4_seq.sv @@
// step counter, control store lookup and jump logic
module md4_seq import md4_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  md4_req_type  req_word,
   input  md4_stat_type stat,
   output md4_uc_type   ctrl
);

   logic [UC_AW-1:0] addr_ff, addr_in;
   md4_ret_type      ret_ff, ret_in;

   always_comb begin
      ctrl = md4_ucode(addr_ff);
   end

   always_comb begin
      addr_in = addr_ff;
      ret_in  = ret_ff;
      unique case (ctrl.op)
         UC_WAIT: begin
            if (req_valid) begin
               if (req_word.byte_present && stat.blk_full) begin
                  ret_in  = req_word.end_of_message ? RET_PAD : RET_IDLE;
                  addr_in = ADDR_LOAD;
               end else if (req_word.end_of_message) begin
                  addr_in = ADDR_PAD;
               end
            end
         end
         UC_LOAD, UC_ROUND: addr_in = addr_ff + UC_AW'(1);
         UC_ADD: begin
            unique case (ret_ff)
               RET_IDLE: addr_in = ADDR_WAIT;
               RET_PAD:  addr_in = ADDR_PAD;
               RET_LEN:  addr_in = ADDR_LEN;
               RET_EMIT: addr_in = ADDR_EMIT;
               default:  addr_in = ADDR_WAIT;
            endcase
         end
         UC_PAD: begin
            if (stat.pos_hi) begin
               ret_in  = RET_LEN;
               addr_in = ADDR_LOAD;
            end else begin
               addr_in = ADDR_LEN;
            end
         end
         UC_LEN: begin
            ret_in  = RET_EMIT;
            addr_in = ADDR_LOAD;
         end
         UC_EMIT: begin
            if (stat.emit_last) begin
               addr_in = ADDR_WAIT;
            end
         end
         default: addr_in = ADDR_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_WAIT;
         ret_ff  <= RET_IDLE;
      end else begin
         addr_ff <= addr_in;
         ret_ff  <= ret_in;
      end
   end

endmodule

@@ rtl/md4_dp.sv @@
// block buffer, chaining words, round unit, length counter and output register
module md4_dp import md4_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  md4_uc_type   ctrl,
   input  logic         req_valid,
   input  md4_req_type  req_word,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output md4_rsp_type  rsp_word,
   output md4_stat_type stat
);

   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [60:0] count_ff, count_in;
   logic [1:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   md4_rsp_type rsp_word_ff, rsp_word_in;

   logic        accept;
   logic        emit_fire;
   logic [5:0]  pos;
   logic [31:0] f_val, k_val, t_val, rot_val;
   logic [5:0]  rot_back;

   assign pos       = count_ff[5:0];
   assign accept    = (ctrl.op == UC_WAIT) && req_valid;
   assign emit_fire = (ctrl.op == UC_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign stat.blk_full  = (pos == 6'h3f);
   assign stat.pos_hi    = (pos[5:3] == 3'b111);
   assign stat.emit_last = emit_fire && (idx_ff == 2'd3);

   // one md4 step
   always_comb begin
      unique case (ctrl.rnd)
         2'd0: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = 32'h0;
         end
         2'd1: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K2;
         end
         default: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K3;
         end
      endcase
      t_val    = a_ff + f_val + blk_ff[ctrl.widx] + k_val;
      rot_back = 6'd32 - {1'b0, ctrl.rot};
      rot_val  = (t_val << ctrl.rot) | (t_val >> rot_back);
   end

   always_comb begin
      blk_in   = blk_ff;
      chain_in = chain_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      unique case (ctrl.op)
         UC_WAIT: begin
            if (accept && req_word.byte_present) begin
               blk_in[pos[5:2]] = blk_ff[pos[5:2]]
                  | ({24'h0, req_word.data_byte} << {pos[1:0], 3'b000});
               count_in = count_ff + 61'd1;
            end
         end
         UC_LOAD: begin
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
         end
         UC_ROUND: begin
            a_in = d_ff;
            d_in = c_ff;
            c_in = b_ff;
            b_in = rot_val;
         end
         UC_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            for (int i = 0; i < 16; i++) begin
               blk_in[i] = 32'h0;
            end
         end
         UC_PAD: begin
            blk_in[pos[5:2]] = blk_ff[pos[5:2]] | (32'h80 << {pos[1:0], 3'b000});
         end
         UC_LEN: begin
            // bit length, little-endian over words 14 and 15
            blk_in[14] = {count_ff[28:0], 3'b000};
            blk_in[15] = count_ff[60:29];
         end
         UC_EMIT: begin
            if (emit_fire) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  chain_in[0] = IV0;
                  chain_in[1] = IV1;
                  chain_in[2] = IV2;
                  chain_in[3] = IV3;
                  count_in    = 61'd0;
               end
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.digest_word = chain_ff[idx_ff];
         rsp_word_in.word_index  = idx_ff;
         rsp_word_in.last_word   = (idx_ff == 2'd3);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            blk_ff[i] <= 32'h0;
         end
         chain_ff[0]  <= IV0;
         chain_ff[1]  <= IV1;
         chain_ff[2]  <= IV2;
         chain_ff[3]  <= IV3;
         count_ff     <= 61'd0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         blk_ff       <= blk_in;
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      d_ff        <= d_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

@@ rtl/md4_message_digest_unit.sv @@
// md4 digest unit top level: microcoded sequencer driving the hash datapath
//
//   channel | direction | word
//   req     | in        | data_byte, byte_present, end_of_message
//   rsp     | out       | digest_word, word_index, last_word
//
// a byte word is taken at the wait step; a word that completes a 64-byte block
// adds a compression (load, 48 round steps, fold into the chaining words).
// an end word adds pad and length steps, one or two compressions,
// then four digest words leave through the output register, one per free cycle.
// req_stall is low only at the wait step of the control store.
// synchronous reset returns the buffer, chaining words and length to start values.
module md4_message_digest_unit import md4_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  md4_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output md4_rsp_type rsp_word
);

   md4_uc_type   ctrl;
   md4_stat_type stat;

   md4_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   md4_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_valid (req_valid),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .stat      (stat)
   );

   assign req_stall = (ctrl.op != UC_WAIT);

endmodule
